FILE: rtl/sal_pkg.sv
// Shared types, constants and helpers for the serial line assembler.
// No dependencies; every other file imports this package.
package sal_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = ADDR_W;
  localparam int MAXLEN_W  = 7;
  localparam int APB_AW    = 2;
  localparam int APB_DW    = 32;

  localparam logic [MAXLEN_W-1:0] MAX_LEN_MIN   = MAXLEN_W'(3);
  localparam logic [MAXLEN_W-1:0] MAX_LEN_TOP   = MAXLEN_W'(BUF_DEPTH);
  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = MAXLEN_W'(BUF_DEPTH);
  localparam logic [LEN_W-1:0]    FILL_MAX      = LEN_W'(BUF_DEPTH - 1);

  localparam logic [APB_AW-1:0] REG_MAX_LEN = APB_AW'(0);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_READ = 2'd1,
    MODE_DONE = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef enum logic {
    BK_IDLE,
    BK_REPLAY
  } bk_state_t;

  // One queued result job from the front end
  typedef struct packed {
    mode_t             status;
    logic              replay;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // Line store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b == CH_TAB) || ((b >= CH_SPACE) && (b != CH_DEL));
  endfunction

endpackage

FILE: rtl/serial_line_assembler_unit.sv
// Serial line assembler top level: stream ports, max_len register, front end,
// job queue and back end. Depends on sal_pkg, sal_front, sal_cmd_queue, sal_back.

// Takes one received byte per transfer and answers each byte with a status
// result; a byte that ends a non-empty line (CR or LF) is answered by the whole
// line, one character per result, with tlast on the final one. An ordinary byte
// goes into the front end's line state in the cycle it is accepted and its
// result is queued for the back end, so input keeps flowing while a result
// waits at the output, as long as the job queue has room. A completed line of N
// characters occupies the back end for N beats, paced by the single read port
// of the 64-entry line store; input is held off from the end-of-line byte
// until the last character has been read. max_len (byte address 0) sets the
// error length and is to be written only while the block is idle; the block
// itself does not enforce this.
module serial_line_assembler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [7:0] line_byte, [13:8] line_length, zero
  output logic [2:0]                    out_tuser,  // [1:0] status, [2] data_valid
  output logic                          out_tlast,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sal_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [sal_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [sal_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import sal_pkg::*;

  logic [MAXLEN_W-1:0] max_len_r;
  logic                cfg_wr;

  cmd_t                q_cmd, q_head;
  store_wr_t           store_wr;
  logic                q_push, q_pop, q_valid, q_full, replay_done;

  logic [1:0]          o_status;
  logic                o_dv;
  logic [7:0]          o_byte;
  logic [LEN_W-1:0]    o_len;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_MAX_LEN);
  assign cfg_prdata = (cfg_paddr == REG_MAX_LEN) ?
                      {{(APB_DW-MAXLEN_W){1'b0}}, max_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= cfg_pwdata[MAXLEN_W-1:0];
    end
  end

  sal_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .rx_byte     (in_tdata),
    .max_len     (max_len_r),
    .q_full      (q_full),
    .replay_done (replay_done),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .store_wr    (store_wr)
  );

  sal_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_head   (q_head)
  );

  sal_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .store_wr        (store_wr),
    .replay_done     (replay_done),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_status      (o_status),
    .out_data_valid  (o_dv),
    .out_line_byte   (o_byte),
    .out_last        (out_tlast),
    .out_line_length (o_len)
  );

  assign out_tdata = {{(16-8-LEN_W){1'b0}}, o_len, o_byte};
  assign out_tuser = {o_dv, o_status};

endmodule

FILE: rtl/sal_front.sv
// Front end: accepts received bytes, runs the line state and fill count,
// writes the line store and queues one result job per byte. Uses sal_pkg.
module sal_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     rx_byte,
  input  logic [sal_pkg::MAXLEN_W-1:0]   max_len,
  input  logic                           q_full,
  input  logic                           replay_done,
  output logic                           q_push,
  output sal_pkg::cmd_t                  q_cmd,
  output sal_pkg::store_wr_t             store_wr
);
  import sal_pkg::*;

  mode_t               mode_r, mode_nxt, mode_base;
  logic [LEN_W-1:0]    fill_r, fill_nxt, fill_base, fill_inc, fill_dec;
  logic                busy_r, busy_nxt;
  logic [MAXLEN_W-1:0] eff_max, err_thr;
  logic                accept;

  assign in_tready = !q_full && !busy_r;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    eff_max = max_len;
    if (max_len < MAX_LEN_MIN) begin
      eff_max = MAX_LEN_MIN;
    end else if (max_len > MAX_LEN_TOP) begin
      eff_max = MAX_LEN_TOP;
    end
    err_thr = eff_max - MAXLEN_W'(1);
  end

  assign fill_inc = (fill_base < FILL_MAX) ? fill_base + LEN_W'(1) : fill_base;
  assign fill_dec = (fill_base != '0) ? fill_base - LEN_W'(1) : '0;

  always_comb begin
    // a finished or failed line is dropped before the new byte is handled
    mode_base = mode_r;
    fill_base = fill_r;
    if (mode_r == MODE_DONE || mode_r == MODE_ERR) begin
      mode_base = MODE_IDLE;
      fill_base = '0;
    end

    mode_nxt      = mode_base;
    fill_nxt      = fill_base;
    store_wr.en   = 1'b0;
    store_wr.addr = fill_base;
    store_wr.data = rx_byte;

    case (mode_base)
      MODE_IDLE: begin
        if (is_printable(rx_byte)) begin
          store_wr.en   = accept;
          store_wr.addr = '0;
          fill_nxt      = LEN_W'(1);
          mode_nxt      = MODE_READ;
        end else begin
          fill_nxt = '0;
        end
      end
      default: begin
        if (is_printable(rx_byte)) begin
          store_wr.en = accept;
          fill_nxt    = fill_inc;
          if ({1'b0, fill_inc} >= err_thr) begin
            mode_nxt = MODE_ERR;
          end
        end else if (rx_byte inside {CH_CR, CH_LF}) begin
          mode_nxt = (fill_base != '0) ? MODE_DONE : MODE_ERR;
        end else if (rx_byte inside {CH_BS, CH_DEL}) begin
          fill_nxt = fill_dec;
          if (fill_dec == '0) begin
            mode_nxt = MODE_IDLE;
          end
        end else begin
          mode_nxt = MODE_IDLE;
          fill_nxt = '0;
        end
      end
    endcase
  end

  assign q_push        = accept;
  assign q_cmd.status  = mode_nxt;
  assign q_cmd.replay  = (mode_nxt == MODE_DONE);
  assign q_cmd.len     = fill_nxt;

  // hold input off from a completed line until its last character has left the store
  always_comb begin
    busy_nxt = busy_r;
    if (replay_done) begin
      busy_nxt = 1'b0;
    end
    if (accept && mode_nxt == MODE_DONE) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      fill_r <= '0;
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (accept) begin
        mode_r <= mode_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

endmodule

FILE: rtl/sal_cmd_queue.sv
// Two-entry queue of result jobs between front end and back end.
// Uses sal_pkg for the job type.
module sal_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sal_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output sal_pkg::cmd_t q_head
);
  import sal_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_head  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/sal_back.sv
// Back end: holds the line store, pops result jobs and drives the output
// register, replaying stored characters one per beat. Uses sal_pkg.
module sal_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sal_pkg::cmd_t       q_head,
  output logic                q_pop,
  input  sal_pkg::store_wr_t  store_wr,
  output logic                replay_done,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [1:0]          out_status,
  output logic                out_data_valid,
  output logic [7:0]          out_line_byte,
  output logic                out_last,
  output logic [sal_pkg::LEN_W-1:0] out_line_length
);
  import sal_pkg::*;

  logic [7:0]         line_mem [BUF_DEPTH];
  logic [7:0]         rd_data_r;

  bk_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;

  logic               ov_r;
  mode_t              ostat_r;
  logic               odv_r, olast_r;
  logic [7:0]         obyte_r;
  logic [LEN_W-1:0]   olen_r;

  logic               out_free, load_direct, load_beat, last_beat;

  assign out_free = !ov_r || out_tready;

  // output decisions
  always_comb begin
    q_pop       = (state_r == BK_IDLE) && q_valid && out_free;
    load_direct = q_pop && !q_head.replay;
    load_beat   = (state_r == BK_REPLAY) && out_free;
    last_beat   = load_beat && (idx_r == ADDR_W'(len_r - LEN_W'(1)));
    replay_done = last_beat;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop && q_head.replay) begin
          state_nxt = BK_REPLAY;
          idx_nxt   = '0;
          len_nxt   = q_head.len;
        end
      end
      BK_REPLAY: begin
        if (last_beat) begin
          state_nxt = BK_IDLE;
        end else if (load_beat) begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    len_r <= len_nxt;
  end

  // line store; read address runs one step ahead so data is ready on each beat
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      line_mem[store_wr.addr] <= store_wr.data;
    end
    rd_data_r <= line_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_direct || load_beat) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      ostat_r <= q_head.status;
      odv_r   <= 1'b0;
      obyte_r <= '0;
      olast_r <= 1'b1;
      olen_r  <= q_head.len;
    end else if (load_beat) begin
      ostat_r <= MODE_DONE;
      odv_r   <= 1'b1;
      obyte_r <= rd_data_r;
      olast_r <= last_beat;
      olen_r  <= len_r;
    end
  end

  assign out_tvalid      = ov_r;
  assign out_status      = ostat_r;
  assign out_data_valid  = odv_r;
  assign out_line_byte   = obyte_r;
  assign out_last        = olast_r;
  assign out_line_length = olen_r;

endmodule

FILE: rtl/sal_checker.sv
// Port-level checks for serial_line_assembler_unit, attached by bind.
// Uses sal_pkg for the status codes.
module sal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import sal_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // replayed characters only come with line-complete status
  a_dv_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == MODE_DONE)
    else $error("line character without complete status");

  // a status-only result is always the last one for its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast)
    else $error("status result without tlast");

  // a replayed line is never empty
  a_replay_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata[13:8] != 6'd0)
    else $error("replayed character with zero line length");

endmodule

bind serial_line_assembler_unit sal_checker u_sal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: verif/serial_line_assembler_unit_test.sv
// Self-checking bench for serial_line_assembler_unit: drives received bytes,
// predicts status and replayed-line results, and checks them field by field.
// Depends on sal_pkg and the serial_line_assembler_unit RTL.
module serial_line_assembler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sal_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PLAN_ROWS   = 28;
  localparam int BYTE_TARGET = 210;

  typedef struct {
    mode_t      status;
    logic       dv;
    logic [7:0] ch;
    logic       last;
    logic [5:0] len;
  } line_result_t;

  typedef struct packed {
    logic       is_cfg;
    logic [7:0] val;
    logic       chk;
    mode_t      st;
    logic [5:0] len;
  } plan_row_t;

  // Directed rows: a byte, or a max_len write (is_cfg). Where chk is set the
  // single status result is typed in; other rows go through the predictor.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{1'b0, 8'h00,    1'b1, MODE_IDLE, 6'd0},
    '{1'b0, CH_CR,    1'b1, MODE_IDLE, 6'd0},
    '{1'b0, 8'h41,    1'b1, MODE_READ, 6'd1},
    '{1'b0, CH_TAB,   1'b1, MODE_READ, 6'd2},
    '{1'b0, 8'hFF,    1'b1, MODE_READ, 6'd3},
    '{1'b0, CH_SPACE, 1'b1, MODE_READ, 6'd4},
    '{1'b0, 8'h7E,    1'b1, MODE_READ, 6'd5},
    '{1'b0, CH_BS,    1'b1, MODE_READ, 6'd4},
    '{1'b0, CH_DEL,   1'b1, MODE_READ, 6'd3},
    '{1'b0, CH_LF,    1'b0, MODE_IDLE, 6'd0},
    '{1'b0, 8'h80,    1'b1, MODE_READ, 6'd1},
    '{1'b0, CH_DEL,   1'b1, MODE_IDLE, 6'd0},
    '{1'b0, 8'h78,    1'b1, MODE_READ, 6'd1},
    '{1'b0, 8'h1B,    1'b1, MODE_IDLE, 6'd0},
    '{1'b0, CH_BS,    1'b1, MODE_IDLE, 6'd0},
    '{1'b0, 8'h61,    1'b1, MODE_READ, 6'd1},
    '{1'b0, 8'h62,    1'b1, MODE_READ, 6'd2},
    '{1'b0, 8'h63,    1'b1, MODE_READ, 6'd3},
    '{1'b0, 8'h64,    1'b1, MODE_READ, 6'd4},
    '{1'b1, 8'd4,     1'b0, MODE_IDLE, 6'd0},
    '{1'b0, 8'h65,    1'b1, MODE_ERR,  6'd5},
    '{1'b1, 8'd0,     1'b0, MODE_IDLE, 6'd0},
    '{1'b0, 8'h68,    1'b1, MODE_READ, 6'd1},
    '{1'b0, 8'h69,    1'b1, MODE_ERR,  6'd2},
    '{1'b0, CH_CR,    1'b1, MODE_IDLE, 6'd0},
    '{1'b0, 8'h5A,    1'b1, MODE_READ, 6'd1},
    '{1'b0, CH_CR,    1'b0, MODE_IDLE, 6'd0},
    '{1'b1, 8'd127,   1'b0, MODE_IDLE, 6'd0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;    // [7:0] rx_byte
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;   // [7:0] line_byte, [13:8] line_length, zero
  logic [2:0]           out_tuser;   // [1:0] status, [2] data_valid
  logic                 out_tlast;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [APB_AW-1:0]    cfg_paddr;
  logic [APB_DW-1:0]    cfg_pwdata;
  logic [APB_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  serial_line_assembler_unit DUT (.*);

  // Line state as the block should hold it
  mode_t        cur_mode;
  int           held;
  logic [7:0]   held_chars [BUF_DEPTH];
  logic [6:0]   cur_max;

  line_result_t pending [$];
  line_result_t head_result;
  int           fail_count;
  int           bytes_sent;
  int           results_seen;
  int           cfg_count;
  int           cycle_count;
  int           hold_cycles;
  logic         took_result;
  logic         tx_calm;
  logic         rx_calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_line(input logic [7:0] b, ref line_result_t found[$]);
    int           lim;
    logic         text;
    line_result_t r;
    found.delete();
    lim = (cur_max < MAX_LEN_MIN) ? MAX_LEN_MIN : (cur_max > MAX_LEN_TOP) ? MAX_LEN_TOP : cur_max;
    text = (b == CH_TAB) || (b >= CH_SPACE && b != CH_DEL);
    // start afresh after a completed or failed line
    if (cur_mode == MODE_DONE || cur_mode == MODE_ERR) begin
      cur_mode = MODE_IDLE;
      held = 0;
    end
    if (cur_mode == MODE_IDLE) begin
      held = 0;
      if (text) begin
        held_chars[0] = b;
        held = 1;
        cur_mode = MODE_READ;
      end
    end else if (text) begin
      held_chars[held] = b;
      if (held < FILL_MAX) held++;
      if (held >= lim - 1) cur_mode = MODE_ERR;
    end else if (b == CH_CR || b == CH_LF) begin
      cur_mode = (held != 0) ? MODE_DONE : MODE_ERR;
    end else if (b == CH_BS || b == CH_DEL) begin
      if (held != 0) held--;
      if (held == 0) cur_mode = MODE_IDLE;
    end else begin
      cur_mode = MODE_IDLE;
      held = 0;
    end
    if (cur_mode == MODE_DONE && held != 0) begin
      for (int i = 0; i < held; i++) begin
        r = '{status: MODE_DONE, dv: 1'b1, ch: held_chars[i], last: (i == held - 1),
              len: 6'(held)};
        found.push_back(r);
      end
    end else begin
      r = '{status: cur_mode, dv: 1'b0, ch: 8'h00, last: 1'b1, len: 6'(held)};
      found.push_back(r);
    end
  endfunction

  function automatic logic [7:0] random_text();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return CH_TAB;
    c = 8'($urandom_range(32, 255));
    return (c == CH_DEL) ? 8'h7E : c;
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic chk, input mode_t st,
                           input logic [5:0] len);
    int           gap;
    line_result_t found [$];
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_line(b, found);
    if (chk) begin
      pending.push_back('{status: st, dv: 1'b0, ch: 8'h00, last: 1'b1, len: len});
    end else begin
      foreach (found[i]) pending.push_back(found[i]);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drain all results, then write max_len and read it back
  task automatic write_max_len(input logic [6:0] v);
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_MAX_LEN;
    cfg_pwdata  <= {25'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {25'd0, v}) begin
      $display("%0t: max_len readback expected %h, got %h", $realtime, {25'd0, v}, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_max = v;
    cfg_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending", cycle_count,
               pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      took_result = 1'b1;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result tuser=%h tdata=%h tlast=%b", $realtime,
                 out_tuser, out_tdata, out_tlast);
        fail_count++;
      end else begin
        head_result = pending.pop_front();
        if (out_tuser[1:0] !== head_result.status || out_tuser[2] !== head_result.dv ||
            out_tdata[7:0] !== head_result.ch || out_tdata[13:8] !== head_result.len ||
            out_tdata[15:14] !== 2'b00 || out_tlast !== head_result.last) begin
          $display("%0t: expected status=%0d dv=%b byte=%h len=%0d last=%b", $realtime,
                   head_result.status, head_result.dv, head_result.ch, head_result.len,
                   head_result.last);
          $display("%0t:   actual status=%0d dv=%b byte=%h len=%0d last=%b pad=%b", $realtime,
                   out_tuser[1:0], out_tuser[2], out_tdata[7:0], out_tdata[13:8], out_tlast,
                   out_tdata[15:14]);
          fail_count++;
        end
      end
    end
  end

  // Result side: draw a stall after every transfer
  always @(negedge clk) begin
    if (took_result) begin
      hold_cycles = rx_calm ? 0 : $urandom_range(0, 15);
      took_result = 1'b0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    int         eff;
    int         want;
    int         n_lines;
    logic [6:0] new_max;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    cur_mode     = MODE_IDLE;
    held         = 0;
    cur_max      = MAX_LEN_RESET;
    fail_count   = 0;
    bytes_sent   = 0;
    results_seen = 0;
    cfg_count    = 0;
    cycle_count  = 0;
    hold_cycles  = 0;
    took_result  = 1'b0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    foreach (held_chars[i]) held_chars[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) write_max_len(PLAN[i].val[6:0]);
      else feed_byte(PLAN[i].val, PLAN[i].chk, PLAN[i].st, PLAN[i].len);
    end

    for (int phase = 0; bytes_sent < BYTE_TARGET; phase++) begin
      if (phase == 0) begin
        new_max = 7'd64;
      end else begin
        case ($urandom_range(0, 5))
          0: new_max = 7'd0;
          1: new_max = 7'd3;
          2: new_max = 7'd127;
          3: new_max = 7'($urandom_range(0, 127));
          default: new_max = 7'($urandom_range(4, 16));
        endcase
      end
      write_max_len(new_max);
      eff = (new_max < MAX_LEN_MIN) ? MAX_LEN_MIN : (new_max > MAX_LEN_TOP) ? MAX_LEN_TOP : new_max;
      tx_calm = (phase % 4 == 2);
      rx_calm = (phase % 4 == 1);
      n_lines = $urandom_range(3, 6);
      for (int ln = 0; ln < n_lines && bytes_sent < BYTE_TARGET; ln++) begin
        // hit the error length or the longest complete line now and then
        if (phase == 0 && ln == 0) want = 62;
        else case ($urandom_range(0, 5))
          0: want = eff - 1;
          1: want = eff - 2;
          default: want = $urandom_range(1, (eff - 2 < 8) ? eff - 2 : 8);
        endcase
        for (int k = 0; k < want && bytes_sent < BYTE_TARGET; k++) begin
          feed_byte(random_text(), 1'b0, MODE_IDLE, 6'd0);
          if ($urandom_range(0, 9) == 0)
            feed_byte($urandom_range(0, 1) ? CH_BS : CH_DEL, 1'b0, MODE_IDLE, 6'd0);
        end
        case ($urandom_range(0, 9))
          0: begin
            // any control byte other than tab, backspace and line ends drops the line
            new_max = 7'($urandom_range(0, 31));
            if (new_max == CH_TAB || new_max == CH_BS || new_max == CH_LF || new_max == CH_CR)
              new_max = 7'h1B;
            feed_byte({1'b0, new_max}, 1'b0, MODE_IDLE, 6'd0);
          end
          1: ;
          default: feed_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0, MODE_IDLE, 6'd0);
        endcase
        if ($urandom_range(0, 3) == 0) feed_byte(8'($urandom_range(0, 255)), 1'b0, MODE_IDLE, 6'd0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes over %0d max_len writes, %0d results checked", bytes_sent,
             cfg_count, results_seen);
    $display("Covered line replay, backspace, drops, error lengths and saturated max_len");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sal_pkg.sv
rtl/sal_front.sv
rtl/sal_cmd_queue.sv
rtl/sal_back.sv
rtl/serial_line_assembler_unit.sv
rtl/sal_checker.sv
verif/serial_line_assembler_unit_test.sv
